// ===== rtl/mfmd_pkg.sv =====
// Shared types and constants for the motor feedback multi-turn decoder.
`timescale 1ns / 1ps
`default_nettype none

package mfmd_pkg;

  // Fixed field widths
  localparam int unsigned FRAME_W       = 64;
  localparam int unsigned GAIN_W        = 24;
  localparam int unsigned GAIN_FRAC     = 16;
  localparam int unsigned ENC_OUT_W     = 25;
  localparam int unsigned STEP_OUT_W    = 25;
  localparam int unsigned TOTAL_W       = 48;
  localparam int unsigned SPEED_W       = 16;
  localparam int unsigned CUR_W         = 24;
  localparam int unsigned TEMP_W        = 8;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 24;

  // Register reset values
  localparam logic [GAIN_W-1:0] INV_GEAR_RST = 24'd65536;
  localparam logic [GAIN_W-1:0] CUR_GAIN_RST = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_GEAR  = 2'd0,
    CFG_CUR_GAIN  = 2'd1,
    CFG_TEMP_PRES = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIV,
    ST_ROUND,
    ST_DIFF,
    ST_MULS,
    ST_MULC,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture input beat
    logic div_init;  // clamp encoder, form constant products
    logic div_step;  // reciprocal multiply for the quotient estimate
    logic round;     // correct quotient, form encoder angle
    logic diff;      // unwrap encoder step
    logic mul_step;  // step magnitude times gear reciprocal
    logic mul_cur;   // scale step, start current multiply
    logic commit;    // update state and output beat
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/motor_feedback_multiturn_decoder.sv =====
// Top level of the motor feedback multi-turn decoder.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                               | Direction | Beat
// --------+-------------------------------------+-----------+-------------------------------
// in      | in_valid_i, in_stall_o, frame_i     | input     | one 8-byte feedback frame
// out     | out_valid_o, out_stall_i, fields    | output    | one decoded frame
// cfg     | cfg_we_i, cfg_index_i, cfg_data_i   | input     | one register write, no wait
//
// Sequence: each frame goes through the accept, clamp and constant products,
//   reciprocal multiply for the encoder quotient, quotient correction, unwrap,
//   two passes through the shared multiplier and the commit, and only then is
//   the next frame accepted. The result beat becomes valid with the commit.
// Reset: asynchronous, active low; the configuration registers return to their
//   defaults and the previous angle, total and held temperature clear to zero.
// Stalls: the output beat sits in its own register, so a new frame is accepted
//   while an earlier result waits; a frame that finishes while the output is
//   still stalled holds in its final state until the slot frees.

module motor_feedback_multiturn_decoder import mfmd_pkg::*; #(
  parameter int unsigned ENCODER_MAX         = 8191,
  parameter int unsigned ANGLE_FRACTION_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]        cfg_data_i,
  // input frames
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [FRAME_W-1:0]           frame_i,
  // results
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [ENC_OUT_W-1:0]         encoder_degrees_o,
  output logic signed [STEP_OUT_W-1:0] step_degrees_o,
  output logic signed [TOTAL_W-1:0]    total_degrees_o,
  output logic signed [SPEED_W-1:0]    speed_o,
  output logic signed [CUR_W-1:0]      current_o,
  output logic [TEMP_W-1:0]            temperature_o,
  output logic                         encoder_clamped_o
);

  cmd_t cmd;

  mfmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  mfmd_datapath #(
    .ENCODER_MAX        (ENCODER_MAX),
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .frame_i          (frame_i),
    .encoder_degrees_o(encoder_degrees_o),
    .step_degrees_o   (step_degrees_o),
    .total_degrees_o  (total_degrees_o),
    .speed_o          (speed_o),
    .current_o        (current_o),
    .temperature_o    (temperature_o),
    .encoder_clamped_o(encoder_clamped_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mfmd_ctrl.sv =====
// Sequencing controller for the multi-turn decoder.
`timescale 1ns / 1ps
`default_nettype none

module mfmd_ctrl import mfmd_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output cmd_t cmd_o
);

  state_e        state_q, state_d;
  logic          out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_MULS;
      end
      ST_MULS: begin
        cmd_o.mul_step = 1'b1;
        state_d        = ST_MULC;
      end
      ST_MULC: begin
        cmd_o.mul_cur = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/mfmd_datapath.sv =====
// Datapath: frame unpack, encoder scaling, unwrap, shared multiplier, accumulator.
`timescale 1ns / 1ps
`default_nettype none

module mfmd_datapath import mfmd_pkg::*; #(
  parameter int unsigned ENCODER_MAX         = 8191,
  parameter int unsigned ANGLE_FRACTION_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cmd_t                         cmd_i,
  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]        cfg_data_i,
  input  wire  [FRAME_W-1:0]           frame_i,
  output logic [ENC_OUT_W-1:0]         encoder_degrees_o,
  output logic signed [STEP_OUT_W-1:0] step_degrees_o,
  output logic signed [TOTAL_W-1:0]    total_degrees_o,
  output logic signed [SPEED_W-1:0]    speed_o,
  output logic signed [CUR_W-1:0]      current_o,
  output logic [TEMP_W-1:0]            temperature_o,
  output logic                         encoder_clamped_o
);

  localparam int unsigned F      = ANGLE_FRACTION_BITS;
  localparam int unsigned EMW    = $clog2(ENCODER_MAX + 1);
  localparam int unsigned EW     = 9 + F;
  localparam int unsigned YW     = 2 * EMW;
  localparam int unsigned MW     = EMW + 2;
  localparam int unsigned MAGW   = 8 + F;
  localparam int unsigned OPW    = (MAGW > 17) ? MAGW : 17;
  localparam int unsigned PW     = OPW + GAIN_W;
  localparam int unsigned RW     = PW - GAIN_FRAC;
  localparam int unsigned SW     = MAGW + 1;

  localparam logic [63:0] HALF64 = 64'd180 << F;
  localparam logic [63:0] FULL64 = 64'd360 << F;
  // full turn = ENC_A * ENCODER_MAX + ENC_B
  localparam logic [63:0] ENC_A64 = FULL64 / 64'(ENCODER_MAX);
  localparam logic [63:0] ENC_B64 = FULL64 % 64'(ENCODER_MAX);
  localparam logic [63:0] RECIP64 = (64'd1 << YW) / 64'(ENCODER_MAX);
  localparam logic [EW-1:0]       ENC_A    = ENC_A64[EW-1:0];
  localparam logic [EMW-1:0]      ENC_B    = ENC_B64[EMW-1:0];
  localparam logic [MW-1:0]       RECIP    = RECIP64[MW-1:0];
  localparam logic [YW-1:0]       ENC_DIV  = YW'(ENCODER_MAX);
  localparam logic [YW-1:0]       ENC_HALF = YW'(ENCODER_MAX / 2);
  localparam logic signed [EW:0]  HALF_D = HALF64[EW:0];
  localparam logic signed [EW:0]  FULL_D = FULL64[EW:0];
  localparam logic [RW-1:0]       HALF_R = HALF64[RW-1:0];
  localparam logic [MAGW-1:0]     HALF_M = HALF64[MAGW-1:0];
  localparam logic [RW-1:0]       CUR_POS_LIM = RW'(24'h7FFFFF);
  localparam logic [RW-1:0]       CUR_NEG_LIM = RW'(24'h800000);
  localparam logic [PW-1:0]       RND_HALF = PW'(32'd32768);
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  // Configuration
  logic [GAIN_W-1:0] inv_gear_q, cur_gain_q;
  logic              temp_pres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_gear_q  <= INV_GEAR_RST;
      cur_gain_q  <= CUR_GAIN_RST;
      temp_pres_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_INV_GEAR:  inv_gear_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_CUR_GAIN:  cur_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_TEMP_PRES: temp_pres_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Frame unpack and encoder clamp
  logic [FRAME_W-1:0] frame_q;
  logic [15:0]        enc_word, cur_word;
  logic [EMW-1:0]     raw;
  logic               clamp;

  always_comb begin
    enc_word = frame_q[63:48];
    cur_word = frame_q[31:16];
    clamp    = 1'b0;
    raw      = EMW'(enc_word);
    if (enc_word[15]) begin
      raw   = '0;
      clamp = 1'b1;
    end else if (enc_word > 16'(ENCODER_MAX)) begin
      raw   = EMW'(ENCODER_MAX);
      clamp = 1'b1;
    end
  end

  // Encoder angle = raw*ENC_A + (raw*ENC_B + half) / ENCODER_MAX. The small
  // quotient comes from a reciprocal multiply that is at most one short, so a
  // single compare of the remainder finishes it.
  logic [EW-1:0]    enc_base_q;
  logic [YW-1:0]    enc_y_q;
  logic [EMW-1:0]   enc_qe_q;
  logic [YW+MW-1:0] enc_prod;
  logic [YW-1:0]    enc_rem;
  logic             enc_carry;

  assign enc_prod  = (YW+MW)'(enc_y_q) * (YW+MW)'(RECIP);
  assign enc_rem   = enc_y_q - YW'(enc_qe_q) * ENC_DIV;
  assign enc_carry = (enc_rem >= ENC_DIV);

  // Unwrap
  logic [EW-1:0]      enc_q, prev_q;
  logic signed [EW:0] diff_raw, diff_uw, diff_abs;

  always_comb begin
    diff_raw = $signed({1'b0, enc_q}) - $signed({1'b0, prev_q});
    diff_uw  = diff_raw;
    if (diff_raw > HALF_D) begin
      diff_uw = diff_raw - FULL_D;
    end else if (diff_raw < -HALF_D) begin
      diff_uw = diff_raw + FULL_D;
    end
    diff_abs = diff_uw[EW] ? -diff_uw : diff_uw;
  end

  // Shared multiplier and rounding
  logic [MAGW-1:0]   mag_q;
  logic              diff_neg_q, cur_neg_q;
  logic [16:0]       cur_mag;
  logic [OPW-1:0]    op_a;
  logic [GAIN_W-1:0] op_b;
  logic [PW-1:0]     prod_q, prod_rnd;
  logic [RW-1:0]     prod_r;

  assign cur_mag  = cur_word[15] ? (17'h10000 - {1'b0, cur_word}) : {1'b0, cur_word};
  assign op_a     = cmd_i.mul_cur ? OPW'(cur_mag) : OPW'(mag_q);
  assign op_b     = cmd_i.mul_cur ? cur_gain_q : inv_gear_q;
  assign prod_rnd = prod_q + RND_HALF;
  assign prod_r   = prod_rnd[PW-1:GAIN_FRAC];

  // Step clamp to half a turn
  logic [MAGW-1:0]      step_mag;
  logic signed [SW-1:0] step_q, step_d;

  always_comb begin
    step_mag = (prod_r > HALF_R) ? HALF_M : prod_r[MAGW-1:0];
    step_d   = diff_neg_q ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
  end

  // Current clamp and total accumulation
  logic [RW-1:0]               cur_lim;
  logic [CUR_W-1:0]            cur_mag_c, cur_d;
  logic signed [TOTAL_W-1:0]   acc_q, total_d;
  logic signed [TOTAL_W:0]     total_sum;

  always_comb begin
    if (cur_neg_q) begin
      cur_lim = (prod_r > CUR_NEG_LIM) ? CUR_NEG_LIM : prod_r;
    end else begin
      cur_lim = (prod_r > CUR_POS_LIM) ? CUR_POS_LIM : prod_r;
    end
    cur_mag_c = cur_lim[CUR_W-1:0];
    cur_d     = cur_neg_q ? (CUR_W'(0) - cur_mag_c) : cur_mag_c;

    total_sum = $signed({acc_q[TOTAL_W-1], acc_q})
              + $signed({{(TOTAL_W+1-SW){step_q[SW-1]}}, step_q});
    if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1]) begin
      total_d = total_sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_d = total_sum[TOTAL_W-1:0];
    end
  end

  // Per-frame working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_q <= frame_i;
    end
    if (cmd_i.div_init) begin
      enc_base_q <= EW'(raw) * ENC_A;
      enc_y_q    <= YW'(raw) * YW'(ENC_B) + ENC_HALF;
    end
    if (cmd_i.div_step) begin
      enc_qe_q <= enc_prod[YW +: EMW];
    end
    if (cmd_i.round) begin
      enc_q <= enc_base_q + EW'(enc_qe_q) + EW'(enc_carry);
    end
    if (cmd_i.diff) begin
      diff_neg_q <= diff_uw[EW];
      mag_q      <= diff_abs[MAGW-1:0];
    end
    if (cmd_i.mul_step || cmd_i.mul_cur) begin
      prod_q <= PW'(op_a) * PW'(op_b);
    end
    if (cmd_i.mul_cur) begin
      step_q    <= step_d;
      cur_neg_q <= cur_word[15];
    end
  end

  // Frame-to-frame state
  logic [TEMP_W-1:0] temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      acc_q  <= '0;
      temp_q <= '0;
    end else if (cmd_i.commit) begin
      prev_q <= enc_q;
      acc_q  <= total_d;
      if (temp_pres_q) begin
        temp_q <= frame_q[15:8];
      end
    end
  end

  // Output beat registers
  logic signed [SW-1:0]      step_out_q;
  logic signed [SPEED_W-1:0] speed_out_q;
  logic signed [CUR_W-1:0]   cur_out_q;
  logic                      clamp_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      step_out_q  <= step_q;
      speed_out_q <= frame_q[47:32];
      cur_out_q   <= cur_d;
      clamp_out_q <= clamp;
    end
  end

  logic [EW+ENC_OUT_W-1:0]  enc_ext;
  logic [SW+STEP_OUT_W-1:0] step_ext;

  assign enc_ext  = {{ENC_OUT_W{1'b0}}, prev_q};
  assign step_ext = {{STEP_OUT_W{step_out_q[SW-1]}}, step_out_q};

  assign encoder_degrees_o = enc_ext[ENC_OUT_W-1:0];
  assign step_degrees_o    = step_ext[STEP_OUT_W-1:0];
  assign total_degrees_o   = acc_q;
  assign speed_o           = speed_out_q;
  assign current_o         = cur_out_q;
  assign temperature_o     = temp_q;
  assign encoder_clamped_o = clamp_out_q;

endmodule

`default_nettype wire
